/* rtl/core/ccc_pkg.sv */
// Shared constants, codes and control/status types of the connected component counter.
package ccc_pkg;

   localparam int MAX_VERTICES = 1024;
   localparam int MAX_EDGES    = 4096;

   localparam int VERT_W     = $clog2(MAX_VERTICES);
   localparam int CNT_W      = VERT_W + 1;
   localparam int EDGE_IDX_W = $clog2(MAX_EDGES);
   localparam int EDGE_CNT_W = EDGE_IDX_W + 1;
   localparam int EDGE_W     = 2 * VERT_W;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 1;

   localparam logic [CSR_IDX_W-1:0] REG_VERTEX_COUNT = 1'b0;

   localparam logic KIND_EDGE  = 1'b0;
   localparam logic KIND_COUNT = 1'b1;

   typedef struct packed {
      logic edge_write;
      logic count_init;
      logic clr_step;
      logic scan_read;
      logic scan_next;
      logic start_comp;
      logic pop;
      logic load_v;
      logic edge_read;
      logic edge_next;
      logic vis_read;
      logic push_w;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic n_zero;
      logic s_last;
      logic visited_bit;
      logic depth_zero;
      logic edge_none;
      logic i_last;
      logic match;
      logic w_free;
      logic rsp_pending;
   } status_type;

endpackage

/* rtl/core/ccc_ctrl.sv */
// Sequencer that steps the clear sweep, the vertex scan and the depth-first walk.
module ccc_ctrl import ccc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_kind,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_CLR      = 4'd1;
   localparam logic [3:0] ST_SCAN_RD  = 4'd2;
   localparam logic [3:0] ST_SCAN_CHK = 4'd3;
   localparam logic [3:0] ST_POP      = 4'd4;
   localparam logic [3:0] ST_POP_W    = 4'd5;
   localparam logic [3:0] ST_EDGE_RD  = 4'd6;
   localparam logic [3:0] ST_EDGE_CHK = 4'd7;
   localparam logic [3:0] ST_VIS_CHK  = 4'd8;
   localparam logic [3:0] ST_FINISH   = 4'd9;

   logic [3:0] state_ff;
   logic [3:0] state_in;
   logic       accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_kind == KIND_EDGE) begin
                  cmd.edge_write = 1'b1;
               end else begin
                  cmd.count_init = 1'b1;
                  state_in = status.n_zero ? ST_FINISH : ST_CLR;
               end
            end
         end
         ST_CLR: begin
            cmd.clr_step = 1'b1;
            if (status.s_last) begin
               state_in = ST_SCAN_RD;
            end
         end
         ST_SCAN_RD: begin
            cmd.scan_read = 1'b1;
            state_in = ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            if (!status.visited_bit) begin
               cmd.start_comp = 1'b1;
               state_in = ST_POP;
            end else if (status.s_last) begin
               state_in = ST_FINISH;
            end else begin
               cmd.scan_next = 1'b1;
               state_in = ST_SCAN_RD;
            end
         end
         ST_POP: begin
            if (!status.depth_zero) begin
               cmd.pop = 1'b1;
               state_in = ST_POP_W;
            end else if (status.s_last) begin
               state_in = ST_FINISH;
            end else begin
               cmd.scan_next = 1'b1;
               state_in = ST_SCAN_RD;
            end
         end
         ST_POP_W: begin
            cmd.load_v = 1'b1;
            state_in = status.edge_none ? ST_POP : ST_EDGE_RD;
         end
         ST_EDGE_RD: begin
            cmd.edge_read = 1'b1;
            state_in = ST_EDGE_CHK;
         end
         ST_EDGE_CHK: begin
            if (status.match) begin
               cmd.vis_read = 1'b1;
               state_in = ST_VIS_CHK;
            end else if (status.i_last) begin
               state_in = ST_POP;
            end else begin
               cmd.edge_next = 1'b1;
               state_in = ST_EDGE_RD;
            end
         end
         ST_VIS_CHK: begin
            cmd.push_w = status.w_free;
            if (status.i_last) begin
               state_in = ST_POP;
            end else begin
               cmd.edge_next = 1'b1;
               state_in = ST_EDGE_RD;
            end
         end
         ST_FINISH: begin
            if (!status.rsp_pending) begin
               cmd.finish = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/core/ccc_datapath.sv */
// Edge store, visited map, search stack, counters and the result register.
module ccc_datapath import ccc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          cmd,
   output status_type       status,
   input  logic [CNT_W-1:0] vertex_limit,
   input  logic [CNT_W-1:0] end_a,
   input  logic [CNT_W-1:0] end_b,
   input  logic             rsp_ready,
   output logic             rsp_valid,
   output logic [CNT_W-1:0] component_count,
   output logic             edges_dropped
);

   logic [EDGE_W-1:0]     edge_mem [MAX_EDGES];
   logic                  vis_mem  [MAX_VERTICES];
   logic [VERT_W-1:0]     stk_mem  [MAX_VERTICES];

   logic [EDGE_CNT_W-1:0] edge_total_ff;
   logic                  dropped_ff;
   logic [VERT_W-1:0]     s_ff;
   logic [EDGE_IDX_W-1:0] i_ff;
   logic [CNT_W-1:0]      depth_ff;
   logic [CNT_W-1:0]      comps_ff;
   logic [VERT_W-1:0]     v_ff;
   logic [VERT_W-1:0]     w_ff;
   logic [EDGE_W-1:0]     edge_rd_ff;
   logic                  vis_rd_ff;
   logic [VERT_W-1:0]     stk_rd_ff;
   logic                  rsp_valid_ff;
   logic [CNT_W-1:0]      rsp_count_ff;
   logic                  rsp_dropped_ff;

   logic                  edge_ok;
   logic [CNT_W-1:0]      a_m1;
   logic [CNT_W-1:0]      b_m1;
   logic [VERT_W-1:0]     x_val;
   logic [VERT_W-1:0]     y_val;
   logic [VERT_W-1:0]     w_in;
   logic                  in_range;
   logic [VERT_W-1:0]     vis_raddr;
   logic                  vis_we;
   logic [VERT_W-1:0]     vis_waddr;
   logic                  vis_wdata;
   logic                  stk_we;
   logic [VERT_W-1:0]     stk_wdata;
   logic [CNT_W-1:0]      depth_m1;

   assign a_m1    = end_a - CNT_W'(1);
   assign b_m1    = end_b - CNT_W'(1);
   assign edge_ok = (end_a != '0) && (end_b != '0) && (end_a <= vertex_limit)
                    && (end_b <= vertex_limit) && (edge_total_ff < EDGE_CNT_W'(MAX_EDGES));

   assign x_val    = edge_rd_ff[EDGE_W-1:VERT_W];
   assign y_val    = edge_rd_ff[VERT_W-1:0];
   assign in_range = ({1'b0, x_val} < vertex_limit) && ({1'b0, y_val} < vertex_limit);
   assign w_in     = (x_val == v_ff) ? y_val : x_val;

   assign vis_raddr = cmd.vis_read ? w_in : s_ff;
   assign vis_we    = cmd.clr_step || cmd.start_comp || cmd.push_w;
   assign vis_waddr = cmd.push_w ? w_ff : s_ff;
   assign vis_wdata = !cmd.clr_step;
   assign stk_we    = cmd.start_comp || cmd.push_w;
   assign stk_wdata = cmd.push_w ? w_ff : s_ff;
   assign depth_m1  = depth_ff - CNT_W'(1);

   always_comb begin
      status.n_zero      = (vertex_limit == '0);
      status.s_last      = ({1'b0, s_ff} == vertex_limit - CNT_W'(1));
      status.visited_bit = vis_rd_ff;
      status.depth_zero  = (depth_ff == '0);
      status.edge_none   = (edge_total_ff == '0);
      status.i_last      = ({1'b0, i_ff} == edge_total_ff - EDGE_CNT_W'(1));
      status.match       = in_range && ((x_val == v_ff) || (y_val == v_ff));
      status.w_free      = !vis_rd_ff && (depth_ff < CNT_W'(MAX_VERTICES));
      status.rsp_pending = rsp_valid_ff;
   end

   // Memories: one write and one registered read port each.
   always_ff @(posedge clock) begin
      if (cmd.edge_write && edge_ok) begin
         edge_mem[edge_total_ff[EDGE_IDX_W-1:0]] <= {a_m1[VERT_W-1:0], b_m1[VERT_W-1:0]};
      end
      if (cmd.edge_read) begin
         edge_rd_ff <= edge_mem[i_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (vis_we) begin
         vis_mem[vis_waddr] <= vis_wdata;
      end
      if (cmd.scan_read || cmd.vis_read) begin
         vis_rd_ff <= vis_mem[vis_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[depth_ff[VERT_W-1:0]] <= stk_wdata;
      end
      if (cmd.pop) begin
         stk_rd_ff <= stk_mem[depth_m1[VERT_W-1:0]];
      end
   end

   // Walk registers.
   always_ff @(posedge clock) begin
      if (cmd.count_init) begin
         s_ff     <= '0;
         comps_ff <= '0;
      end else begin
         if (cmd.clr_step) begin
            s_ff <= status.s_last ? '0 : s_ff + VERT_W'(1);
         end else if (cmd.scan_next) begin
            s_ff <= s_ff + VERT_W'(1);
         end
         if (cmd.start_comp) begin
            comps_ff <= comps_ff + CNT_W'(1);
         end
      end
      if (cmd.count_init) begin
         depth_ff <= '0;
      end else if (cmd.start_comp) begin
         depth_ff <= CNT_W'(1);
      end else if (cmd.push_w) begin
         depth_ff <= depth_ff + CNT_W'(1);
      end else if (cmd.pop) begin
         depth_ff <= depth_m1;
      end
      if (cmd.pop) begin
         i_ff <= '0;
      end else if (cmd.edge_next) begin
         i_ff <= i_ff + EDGE_IDX_W'(1);
      end
      if (cmd.load_v) begin
         v_ff <= stk_rd_ff;
      end
      if (cmd.vis_read) begin
         w_ff <= w_in;
      end
      if (cmd.finish) begin
         rsp_count_ff   <= comps_ff;
         rsp_dropped_ff <= dropped_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         edge_total_ff <= '0;
         dropped_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (cmd.finish) begin
            edge_total_ff <= '0;
            dropped_ff    <= 1'b0;
         end else if (cmd.edge_write) begin
            if (edge_ok) begin
               edge_total_ff <= edge_total_ff + EDGE_CNT_W'(1);
            end else begin
               dropped_ff <= 1'b1;
            end
         end
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign component_count = rsp_count_ff;
   assign edges_dropped   = rsp_dropped_ff;

   a_edge_stored: assert property (@(posedge clock) disable iff (reset)
      cmd.edge_write && edge_ok |=> edge_total_ff == $past(edge_total_ff) + EDGE_CNT_W'(1))
      else $error("stored edge did not advance the edge total");

   a_finish_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid_ff && (edge_total_ff == '0) && !dropped_ff)
      else $error("finishing a count did not clear the graph and post a result");

   a_walk_starts_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.start_comp |-> depth_ff == '0)
      else $error("new component started with a non-empty stack");

   a_store_bound: assert property (@(posedge clock) disable iff (reset)
      edge_total_ff <= EDGE_CNT_W'(MAX_EDGES))
      else $error("edge total beyond store capacity");

endmodule

/* rtl/core/connected_component_counter.sv */
// Connected component counter: request handshake, register port and the sequencer/datapath pair.
// Edge beat: accepted back to back while the block is idle.
// Count beat: accept, clear sweep, read and check per scanned vertex, check per component as its
// stack empties, pop and load per popped vertex, read and check per stored edge (plus a visited
// check on a touching edge), finish held while an earlier result waits; no beat is taken meanwhile.
// Reset clears control, the edge total and the drop flag; memories are not reset, the visited
// map being swept clear at the start of every count.
module connected_component_counter import ccc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_kind,
   input  logic [CNT_W-1:0]      req_end_a,
   input  logic [CNT_W-1:0]      req_end_b,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [CNT_W-1:0]      rsp_component_count,
   output logic                  rsp_edges_dropped,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   // The register index is the word address; the two low byte-address bits are ignored.
   logic [CNT_W-1:0]     vertex_count_ff;
   logic [CNT_W-1:0]     vertex_limit;
   logic [CSR_IDX_W-1:0] csr_index;
   logic                 csr_write;
   cmd_type              cmd;
   status_type           status;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= '0;
      end else if (csr_write && (csr_index == REG_VERTEX_COUNT)) begin
         vertex_count_ff <= csr_pwdata[CNT_W-1:0];
      end
   end

   assign csr_prdata = (csr_index == REG_VERTEX_COUNT) ?
                       CSR_DATA_W'(vertex_count_ff) : '0;

   // A vertex count above the supported maximum saturates.
   assign vertex_limit = (vertex_count_ff > CNT_W'(MAX_VERTICES)) ?
                         CNT_W'(MAX_VERTICES) : vertex_count_ff;

   ccc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_kind  (req_kind),
      .status    (status),
      .cmd       (cmd)
   );

   ccc_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .vertex_limit    (vertex_limit),
      .end_a           (req_end_a),
      .end_b           (req_end_b),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .component_count (rsp_component_count),
      .edges_dropped   (rsp_edges_dropped)
   );

endmodule

/* tb/connected_component_counter_tb.sv */
// Self-checking testbench for the connected component counter: directed table, then random graphs.
module connected_component_counter_tb;
   import ccc_pkg::*;

   localparam int HALF_PERIOD  = 5;
   localparam int CYCLE_LIMIT  = 20_000_000;
   localparam int RANDOM_ITEMS = 900;

   // One row of the directed stimulus table. A count row may carry a result typed in
   // by hand; the predictor is checked against it as well as against the block.
   typedef struct {
      logic             kind;
      logic [CNT_W-1:0] end_a;
      logic [CNT_W-1:0] end_b;
      logic             has_known;
      logic [CNT_W-1:0] known_count;
      logic             known_dropped;
   } stim_row_type;

   typedef struct packed {
      logic [CNT_W-1:0] component_count;
      logic             edges_dropped;
   } tally_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_kind = 1'b0;
   logic [CNT_W-1:0]      req_end_a = '0;
   logic [CNT_W-1:0]      req_end_b = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [CNT_W-1:0]      rsp_component_count;
   logic                  rsp_edges_dropped;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   connected_component_counter dut (.*);

   always #HALF_PERIOD clock = ~clock;

   // Shadow of the block's graph state, used by the component predictor.
   logic [VERT_W-1:0] graph_lo [MAX_EDGES];
   logic [VERT_W-1:0] graph_hi [MAX_EDGES];
   int unsigned       graph_edges;
   logic              graph_dropped;
   logic [CNT_W-1:0]  graph_vertices;

   tally_type   tally_queue[$];
   int unsigned error_total = 0;
   int unsigned cycle_count = 0;
   bit          idle_allowed = 1'b1;
   bit          req_burst_on = 1'b0;
   // Set while a beat is being offered, so that valid is lowered once only.
   bit          req_live = 1'b0;

   task automatic report_mismatch(input string what);
      $display("ERROR at cycle %0d: %s", cycle_count, what);
      error_total++;
   endtask

   function automatic int unsigned live_vertices();
      return (graph_vertices > MAX_VERTICES) ? MAX_VERTICES : graph_vertices;
   endfunction

   // Counts components with a union-find over the stored edges. It gives the same
   // answer as a depth-first walk and is independent of the block's method.
   function automatic int unsigned count_components();
      int unsigned parent [MAX_VERTICES];
      int unsigned n;
      int unsigned comps;
      int unsigned ra;
      int unsigned rb;
      n = live_vertices();
      comps = n;
      for (int v = 0; v < n; v++) parent[v] = v;
      for (int i = 0; i < graph_edges; i++) begin
         // Edges touching a vertex beyond the present count are ignored.
         if (graph_lo[i] >= n || graph_hi[i] >= n) continue;
         ra = graph_lo[i];
         while (parent[ra] != ra) ra = parent[ra];
         rb = graph_hi[i];
         while (parent[rb] != rb) rb = parent[rb];
         if (ra != rb) begin
            parent[ra] = rb;
            comps--;
         end
      end
      return comps;
   endfunction

   // Applies one accepted beat to the shadow state and queues any expected result.
   task automatic predict_beat(input logic kind, input logic [CNT_W-1:0] a,
                               input logic [CNT_W-1:0] b);
      tally_type t;
      int unsigned n;
      n = live_vertices();
      if (kind == KIND_EDGE) begin
         if (a == 0 || b == 0 || a > n || b > n || graph_edges >= MAX_EDGES) begin
            graph_dropped = 1'b1;
         end else begin
            graph_lo[graph_edges] = VERT_W'(a - 1);
            graph_hi[graph_edges] = VERT_W'(b - 1);
            graph_edges++;
         end
      end else begin
         t.component_count = CNT_W'(count_components());
         t.edges_dropped   = graph_dropped;
         tally_queue = {tally_queue, t};
         graph_edges   = 0;
         graph_dropped = 1'b0;
      end
   endtask

   // Drives one beat and holds it until the block takes it. Valid stays high after
   // acceptance and is lowered by the next idle gap or the next wait for results.
   task automatic send_beat(input logic kind, input logic [CNT_W-1:0] a,
                            input logic [CNT_W-1:0] b);
      if (idle_allowed && req_burst_on) begin
         if (req_live) req_valid <= 1'b0;
         req_live = 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_burst_on = ($urandom_range(0, 5) == 0);
      req_valid <= 1'b1;
      req_kind  <= kind;
      req_end_a <= a;
      req_end_b <= b;
      req_live = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_beat(kind, a, b);
   endtask

   task automatic wait_drained();
      if (req_live) req_valid <= 1'b0;
      req_live = 1'b0;
      while (tally_queue.size() != 0) @(posedge clock);
   endtask

   // Writes the vertex count through the register port: setup cycle, then access cycle.
   task automatic write_vertex_count(input logic [CNT_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(4 * REG_VERTEX_COUNT);
      csr_pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      graph_vertices = value;
   endtask

   // Result side: random ready bursts, and a field-by-field check against the oldest
   // expectation at each accepted beat.
   always @(posedge clock) begin
      tally_type want;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid && rsp_ready) begin
         if (tally_queue.size() == 0) begin
            report_mismatch("result beat with nothing expected");
         end else begin
            want = tally_queue.pop_front();
            if (rsp_component_count !== want.component_count)
               report_mismatch($sformatf("component_count %0d, expected %0d",
                                         rsp_component_count, want.component_count));
            if (rsp_edges_dropped !== want.edges_dropped)
               report_mismatch($sformatf("edges_dropped %0b, expected %0b",
                                         rsp_edges_dropped, want.edges_dropped));
         end
      end
      if (reset) rsp_ready <= 1'b0;
      else if (idle_allowed) rsp_ready <= ($urandom_range(0, 3) != 0);
      else rsp_ready <= 1'b1;
   end

   always @(posedge clock) begin
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   stim_row_type directed [$];

   function automatic stim_row_type row_edge(input int a, input int b);
      stim_row_type r;
      r.kind = KIND_EDGE;
      r.end_a = CNT_W'(a);
      r.end_b = CNT_W'(b);
      r.has_known = 1'b0;
      r.known_count = '0;
      r.known_dropped = 1'b0;
      return r;
   endfunction

   function automatic stim_row_type row_count(input bit known, input int c, input bit d);
      stim_row_type r;
      r.kind = KIND_COUNT;
      r.end_a = '1;
      r.end_b = '1;
      r.has_known = known;
      r.known_count = CNT_W'(c);
      r.known_dropped = d;
      return r;
   endfunction

   // Appends one row to the directed table.
   task automatic queue_row(input stim_row_type r);
      directed = {directed, r};
   endtask

   // Sends a random graph on n vertices: mostly chains and clusters of in-range edges,
   // with now and then an out-of-range endpoint, then a count.
   task automatic send_random_graph(input int unsigned n, input int unsigned edges,
                                    inout int unsigned sent);
      int unsigned a;
      int unsigned b;
      for (int i = 0; i < edges; i++) begin
         if ($urandom_range(0, 19) == 0) begin
            a = $urandom_range(0, 2047);
            b = $urandom_range(0, 2047);
         end else if (n == 0) begin
            a = 1;
            b = 1;
         end else begin
            a = $urandom_range(1, n);
            b = ($urandom_range(0, 2) == 0) ? a : $urandom_range(1, n);
            if ($urandom_range(0, 3) == 0 && a < n) b = a + 1;
         end
         send_beat(KIND_EDGE, CNT_W'(a), CNT_W'(b));
         sent++;
      end
      send_beat(KIND_COUNT, CNT_W'($urandom_range(0, 2047)), CNT_W'($urandom_range(0, 2047)));
      sent++;
   endtask

   initial begin
      int unsigned sent;
      int unsigned n;
      int unsigned got;
      stim_row_type r;
      graph_edges = 0;
      graph_dropped = 1'b0;
      graph_vertices = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. With zero vertices after reset the count is zero and every edge
      // is dropped as out of range.
      queue_row(row_count(1, 0, 0));
      queue_row(row_edge(1, 1));
      queue_row(row_count(1, 0, 1));
      foreach (directed[i]) begin
         r = directed[i];
         send_beat(r.kind, r.end_a, r.end_b);
         if (r.has_known && (tally_queue[$].component_count !== r.known_count ||
                             tally_queue[$].edges_dropped !== r.known_dropped))
            report_mismatch($sformatf("predictor disagrees with table row %0d", i));
      end
      wait_drained();

      // Largest count written as an oversize value, saturating to the maximum.
      write_vertex_count(CNT_W'(2047));
      directed.delete();
      queue_row(row_count(1, MAX_VERTICES, 0));
      queue_row(row_edge(1, MAX_VERTICES));
      queue_row(row_edge(MAX_VERTICES, MAX_VERTICES));
      queue_row(row_edge(0, 5));
      queue_row(row_count(1, MAX_VERTICES - 1, 1));
      queue_row(row_edge(1025, 2));
      queue_row(row_edge(2047, 2047));
      queue_row(row_count(1, MAX_VERTICES, 1));
      foreach (directed[i]) begin
         r = directed[i];
         send_beat(r.kind, r.end_a, r.end_b);
         if (r.has_known && (tally_queue[$].component_count !== r.known_count ||
                             tally_queue[$].edges_dropped !== r.known_dropped))
            report_mismatch($sformatf("predictor disagrees with table row %0d", i));
      end
      wait_drained();

      // Small graph, then lower the count so that stored edges touch dropped vertices.
      write_vertex_count(CNT_W'(6));
      directed.delete();
      queue_row(row_edge(1, 2));
      queue_row(row_edge(2, 3));
      queue_row(row_edge(5, 6));
      queue_row(row_edge(4, 4));
      queue_row(row_edge(7, 1));
      queue_row(row_count(1, 3, 1));
      queue_row(row_edge(1, 6));
      queue_row(row_edge(2, 3));
      foreach (directed[i]) begin
         r = directed[i];
         send_beat(r.kind, r.end_a, r.end_b);
         if (r.has_known && (tally_queue[$].component_count !== r.known_count ||
                             tally_queue[$].edges_dropped !== r.known_dropped))
            report_mismatch($sformatf("predictor disagrees with table row %0d", i));
      end
      wait_drained();
      write_vertex_count(CNT_W'(3));
      send_beat(KIND_COUNT, '0, '0);
      if (tally_queue[$].component_count !== CNT_W'(2))
         report_mismatch("predictor disagrees on lowered vertex count");

      // Random graphs; mostly small vertex counts, a few large.
      sent = 0;
      got = 0;
      while (sent < RANDOM_ITEMS || got < 40) begin
         if (sent > RANDOM_ITEMS * 3 / 4) idle_allowed = 1'b0;
         wait_drained();
         // The count beat may still be finishing; allow a short settling gap.
         repeat (4) @(posedge clock);
         case ($urandom_range(0, 9))
            0: n = $urandom_range(0, 1);
            1: n = $urandom_range(1000, 1100);
            default: n = $urandom_range(2, 24);
         endcase
         write_vertex_count(CNT_W'(n));
         send_random_graph(n, $urandom_range(0, (n > 100) ? 60 : 30), sent);
         got++;
         // Once, hold the sender off until every expected result has come back.
         if (got == 10) wait_drained();
      end

      wait_drained();
      repeat (50) @(posedge clock);
      if (error_total == 0 && tally_queue.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
